// File: src/skp_pkg.sv
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants of the softened point-mass potential pipeline.
// ----------------------------------------------------------------------------
package skp_pkg;

   // Width of the unsigned magnitudes carried through the kernel.
   localparam int CALC_BITS = 64;

   // Number of register stages of one fixed-point product unit.
   localparam int QMUL_LAT = 4;

   typedef enum logic [1:0] {
      CSR_MASS_TERM     = 2'd0,
      CSR_SOFTENING_SQ  = 2'd1,
      CSR_KERNEL_SELECT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KERNEL_PLUMMER = 2'd0,
      KERNEL_P1      = 2'd1,
      KERNEL_P2      = 2'd2,
      KERNEL_P3      = 2'd3
   } kernel_type;

endpackage

// File: src/skp_channels.sv
// ----------------------------------------------------------------------------
// skp channels
// Valid/ready channels for distance beats in and potential beats out.
// ----------------------------------------------------------------------------
interface skp_req_if #(parameter int WORD_BITS = 48);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] radius_sq;

   modport source (output valid, output radius_sq, input ready);
   modport sink   (input valid, input radius_sq, output ready);
endinterface

interface skp_rsp_if #(parameter int WORD_BITS = 48);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] potential;
   logic signed [WORD_BITS-1:0] force_factor;

   modport source (output valid, output potential, output force_factor, input ready);
   modport sink   (input valid, input potential, input force_factor, output ready);
endinterface

// File: src/skp_qmul.sv
// ----------------------------------------------------------------------------
// skp_qmul
// Pipelined saturating fixed-point product: addend + SCALE * (a * b >> FRAC).
// ----------------------------------------------------------------------------
module skp_qmul
   import skp_pkg::*;
#(
   parameter int FRAC_BITS = 24,
   parameter int SCALE     = 1
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [CALC_BITS-1:0] op_a,
   input  logic [CALC_BITS-1:0] op_b,
   input  logic [CALC_BITS-1:0] addend,
   output logic [CALC_BITS-1:0] result
);

   localparam int HALF = CALC_BITS / 2;
   localparam int PW   = 2 * CALC_BITS;
   localparam int SW   = CALC_BITS + 3;

   logic [CALC_BITS-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [CALC_BITS-1:0] add1_ff, add2_ff, add3_ff;
   logic [PW-1:0]        sum_ff;
   logic [CALC_BITS-1:0] scl_ff;
   logic [CALC_BITS-1:0] result_ff;

   logic [PW-1:0]        sum_in;
   logic [CALC_BITS-1:0] shr;
   logic [SW-1:0]        scaled;
   logic [CALC_BITS-1:0] scl_in;
   logic [CALC_BITS:0]   tot;
   logic [CALC_BITS-1:0] result_in;

   always_comb begin
      sum_in = {p11_ff, p00_ff}
             + PW'({p01_ff, {HALF{1'b0}}})
             + PW'({p10_ff, {HALF{1'b0}}});
   end

   always_comb begin
      // The shifted product saturates when it needs more than the full word.
      if (sum_ff[PW-1 -: (CALC_BITS - FRAC_BITS)] != '0) begin
         shr = '1;
      end else begin
         shr = sum_ff[FRAC_BITS +: CALC_BITS];
      end
      scaled = SW'(shr) * SW'(SCALE);
      if (scaled[SW-1 -: 3] != '0) begin
         scl_in = '1;
      end else begin
         scl_in = scaled[CALC_BITS-1:0];
      end
   end

   always_comb begin
      tot = {1'b0, scl_ff} + {1'b0, add3_ff};
      if (tot[CALC_BITS]) begin
         result_in = '1;
      end else begin
         result_in = tot[CALC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff    <= CALC_BITS'(op_a[HALF-1:0])         * CALC_BITS'(op_b[HALF-1:0]);
         p01_ff    <= CALC_BITS'(op_a[HALF-1:0])         * CALC_BITS'(op_b[CALC_BITS-1:HALF]);
         p10_ff    <= CALC_BITS'(op_a[CALC_BITS-1:HALF]) * CALC_BITS'(op_b[HALF-1:0]);
         p11_ff    <= CALC_BITS'(op_a[CALC_BITS-1:HALF]) * CALC_BITS'(op_b[CALC_BITS-1:HALF]);
         add1_ff   <= addend;
         sum_ff    <= sum_in;
         add2_ff   <= add1_ff;
         scl_ff    <= scl_in;
         add3_ff   <= add2_ff;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/softened_kernel_potential.sv
// ----------------------------------------------------------------------------
// softened_kernel_potential
// Potential and radial force factor of a softened point mass, one beat per
// cycle. Each distance beat gives exactly one result beat, in order. The
// pipeline is a register for the distance sum, one reciprocal stage per
// quotient bit, a reciprocal output register, one square-root stage per
// root bit, a saturating product unit for each of the eight dependent
// products (m1 to m4, three kernel weighting steps and the mass factor) and
// a final sign stage. The whole pipeline holds while a result beat waits at
// the output, and a new beat is taken in every cycle that it moves.
// Configuration is read live, so the user must write it only while no beat
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module softened_kernel_potential
   import skp_pkg::*;
#(
   parameter int FRAC_BITS = 24,
   parameter int WORD_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   skp_req_if.sink              req_ch,
   skp_rsp_if.source            rsp_ch,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_wdata
);

   localparam int DS  = 2 * FRAC_BITS + 1;
   localparam int SQ  = (CALC_BITS + FRAC_BITS + 1) / 2;
   localparam int YW  = 2 * SQ;
   localparam int QL  = QMUL_LAT;
   localparam int XD  = SQ + 3 * QL;
   localparam int MD  = 7 * QL;
   localparam int T_F = 1 + DS + 1 + SQ + 8 * QL + 1;

   // ------------------------------------------------------------------ csr
   logic [WORD_BITS-1:0] mass_ff;
   logic [WORD_BITS-1:0] soft_ff;
   kernel_type           kernel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff   <= WORD_BITS'(CALC_BITS'(1) << FRAC_BITS);
         soft_ff   <= WORD_BITS'(CALC_BITS'(1) << FRAC_BITS);
         kernel_ff <= KERNEL_PLUMMER;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_MASS_TERM:     mass_ff   <= csr_wdata;
            CSR_SOFTENING_SQ:  soft_ff   <= csr_wdata;
            CSR_KERNEL_SELECT: kernel_ff <= kernel_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   logic [CALC_BITS-1:0] e2, h_w, q_w;
   logic                 k_p3, k_ge2, k_plain;

   assign e2      = CALC_BITS'(soft_ff);
   assign h_w     = e2 >> 1;
   assign q_w     = e2 >> 2;
   assign k_p3    = (kernel_ff == KERNEL_P3);
   assign k_ge2   = (kernel_ff == KERNEL_P2) || (kernel_ff == KERNEL_P3);
   assign k_plain = (kernel_ff == KERNEL_PLUMMER);

   // ------------------------------------------------------- flow control
   logic [T_F:1] vld_ff;
   logic         en;

   assign en           = !vld_ff[T_F] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[T_F];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[T_F-1:1], req_ch.valid};
      end
   end

   // ------------------------------------------------------- distance sum
   logic [CALC_BITS:0]   ssum;
   logic [CALC_BITS-1:0] s_in, s_ff;

   always_comb begin
      ssum = (CALC_BITS + 1)'(CALC_BITS'(req_ch.radius_sq)) + (CALC_BITS + 1)'(e2);
      if (ssum[CALC_BITS]) begin
         s_in = '1;
      end else if (ssum[CALC_BITS-1:0] == '0) begin
         // A zero sum is taken as one LSB so that the outputs saturate.
         s_in = CALC_BITS'(1);
      end else begin
         s_in = ssum[CALC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
      end
   end

   // ----------------------------------------- reciprocal, a bit per stage
   logic [CALC_BITS-1:0] div_rem_ff [1:DS];
   logic [DS-1:0]        div_q_ff   [1:DS];
   logic [CALC_BITS-1:0] div_s_ff   [1:DS];

   for (genvar i = 1; i <= DS; i++) begin : g_div
      logic [CALC_BITS-1:0] rem_prev, s_prev;
      logic [DS-1:0]        q_prev;
      logic [CALC_BITS:0]   shifted;
      logic                 ge;

      if (i == 1) begin : g_first
         assign rem_prev = '0;
         assign q_prev   = '0;
         assign s_prev   = s_ff;
      end else begin : g_next
         assign rem_prev = div_rem_ff[i-1];
         assign q_prev   = div_q_ff[i-1];
         assign s_prev   = div_s_ff[i-1];
      end

      // The dividend is a single one at its top bit.
      assign shifted = {rem_prev, (i == 1) ? 1'b1 : 1'b0};
      assign ge      = shifted >= {1'b0, s_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            div_rem_ff[i] <= ge ? CALC_BITS'(shifted - {1'b0, s_prev})
                                : shifted[CALC_BITS-1:0];
            div_q_ff[i]   <= {q_prev[DS-2:0], ge};
            div_s_ff[i]   <= s_prev;
         end
      end
   end

   logic [CALC_BITS:0]   q_ext;
   logic [CALC_BITS-1:0] x_ff;

   assign q_ext = (CALC_BITS + 1)'(div_q_ff[DS]);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= q_ext[CALC_BITS] ? '1 : q_ext[CALC_BITS-1:0];
      end
   end

   logic [CALC_BITS-1:0] x_dly_ff [1:XD];

   always_ff @(posedge clock) begin
      if (en) begin
         x_dly_ff[1] <= x_ff;
         for (int d = 2; d <= XD; d++) begin
            x_dly_ff[d] <= x_dly_ff[d-1];
         end
      end
   end

   // ------------------------------------ square root, a bit per stage
   logic [SQ+1:0] sq_rem_ff  [1:SQ];
   logic [SQ-1:0] sq_root_ff [1:SQ];

   for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
      logic [CALC_BITS-1:0] x_cur;
      logic [SQ+1:0]        rem_prev;
      logic [SQ-1:0]        root_prev;
      logic [YW-1:0]        y_w;
      logic [SQ+3:0]        shifted, trial;
      logic                 ge;

      if (j == 1) begin : g_first
         assign x_cur     = x_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_cur     = x_dly_ff[j-1];
         assign rem_prev  = sq_rem_ff[j-1];
         assign root_prev = sq_root_ff[j-1];
      end

      assign y_w     = YW'({x_cur, {FRAC_BITS{1'b0}}});
      assign shifted = {rem_prev, y_w[YW-1-2*(j-1) -: 2]};
      assign trial   = (SQ + 4)'({root_prev, 2'b01});
      assign ge      = shifted >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[j]  <= ge ? (SQ + 2)'(shifted - trial) : (SQ + 2)'(shifted);
            sq_root_ff[j] <= {root_prev[SQ-2:0], ge};
         end
      end
   end

   // ------------------------------------------------ derivative chain
   logic [CALC_BITS-1:0] m_src   [0:3];
   logic [CALC_BITS-1:0] mdly_ff [0:3][1:MD];
   logic [CALC_BITS-1:0] m4;

   assign m_src[0] = CALC_BITS'(sq_root_ff[SQ]);

   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_m1 (
      .clock(clock), .en(en), .op_a(x_dly_ff[SQ]), .op_b(m_src[0]),
      .addend('0), .result(m_src[1])
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(3)) u_m2 (
      .clock(clock), .en(en), .op_a(x_dly_ff[SQ+QL]), .op_b(m_src[1]),
      .addend('0), .result(m_src[2])
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(5)) u_m3 (
      .clock(clock), .en(en), .op_a(x_dly_ff[SQ+2*QL]), .op_b(m_src[2]),
      .addend('0), .result(m_src[3])
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(7)) u_m4 (
      .clock(clock), .en(en), .op_a(x_dly_ff[SQ+3*QL]), .op_b(m_src[3]),
      .addend('0), .result(m4)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            mdly_ff[k][1] <= m_src[k];
            for (int d = 2; d <= MD; d++) begin
               mdly_ff[k][d] <= mdly_ff[k][d-1];
            end
         end
      end
   end

   // ---------------------------------------- kernel weighting, Horner
   // Force side: a = m3 + h*m4, b = m2 + w*(a or m3), c = m1 + h*(b or m2).
   logic [CALC_BITS-1:0] f_a, f_b, f_c;
   logic [CALC_BITS-1:0] p_a, p_b, p_c;

   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_fa (
      .clock(clock), .en(en), .op_a(h_w), .op_b(m4),
      .addend(mdly_ff[3][QL]), .result(f_a)
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_fb (
      .clock(clock), .en(en), .op_a(k_p3 ? q_w : h_w),
      .op_b(k_p3 ? f_a : mdly_ff[3][2*QL]),
      .addend(mdly_ff[2][3*QL]), .result(f_b)
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_fc (
      .clock(clock), .en(en), .op_a(h_w),
      .op_b(k_ge2 ? f_b : mdly_ff[2][4*QL]),
      .addend(mdly_ff[1][5*QL]), .result(f_c)
   );

   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_pa (
      .clock(clock), .en(en), .op_a(h_w), .op_b(mdly_ff[3][QL]),
      .addend(mdly_ff[2][2*QL]), .result(p_a)
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_pb (
      .clock(clock), .en(en), .op_a(k_p3 ? q_w : h_w),
      .op_b(k_p3 ? p_a : mdly_ff[2][3*QL]),
      .addend(mdly_ff[1][4*QL]), .result(p_b)
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_pc (
      .clock(clock), .en(en), .op_a(h_w),
      .op_b(k_ge2 ? p_b : mdly_ff[1][5*QL]),
      .addend(mdly_ff[0][6*QL]), .result(p_c)
   );

   // ---------------------------------------------------- mass factor
   logic                 gm_neg;
   logic [WORD_BITS-1:0] gabs;
   logic [CALC_BITS-1:0] gabs_ext;
   logic [CALC_BITS-1:0] pot_mag, frc_mag;

   assign gm_neg   = mass_ff[WORD_BITS-1];
   assign gabs     = gm_neg ? (WORD_BITS'(0) - mass_ff) : mass_ff;
   assign gabs_ext = CALC_BITS'(gabs);

   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_pot (
      .clock(clock), .en(en), .op_a(gabs_ext),
      .op_b(k_plain ? mdly_ff[0][7*QL] : p_c),
      .addend('0), .result(pot_mag)
   );
   skp_qmul #(.FRAC_BITS(FRAC_BITS), .SCALE(1)) u_frc (
      .clock(clock), .en(en), .op_a(gabs_ext),
      .op_b(k_plain ? mdly_ff[1][6*QL] : f_c),
      .addend('0), .result(frc_mag)
   );

   // ------------------------------------------------- sign and output
   localparam logic [CALC_BITS-1:0] TOP = CALC_BITS'(1) << (WORD_BITS - 1);

   function automatic logic [WORD_BITS-1:0] signed_sat(
      input logic [CALC_BITS-1:0] mag,
      input logic                 neg_mass
   );
      logic [CALC_BITS-1:0] lim;
      logic [CALC_BITS-1:0] neg;
      if (neg_mass) begin
         lim = (mag > TOP - 1) ? TOP - 1 : mag;
         return lim[WORD_BITS-1:0];
      end
      lim = (mag > TOP) ? TOP : mag;
      neg = CALC_BITS'(0) - lim;
      return neg[WORD_BITS-1:0];
   endfunction

   logic [WORD_BITS-1:0] pot_ff, frc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pot_ff <= signed_sat(pot_mag, gm_neg);
         frc_ff <= signed_sat(frc_mag, gm_neg);
      end
   end

   assign rsp_ch.potential    = pot_ff;
   assign rsp_ch.force_factor = frc_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_kernel_potential testbench
// Sends squared distances under a set of mass, softening and kernel settings.
// Each result is checked against a bit-accurate fixed-point prediction of the
// softened potential and force factor. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import skp_pkg::*;

   localparam int FRAC = 24;
   localparam int WB   = 48;
   localparam logic [63:0] SAT64 = '1;
   localparam logic [WB-1:0] WMAX = '1;

   typedef struct packed {
      logic [WB-1:0] potential;
      logic [WB-1:0] force_factor;
   } potential_beat_t;

   logic clock = 1'b0;
   logic reset;
   logic          csr_wen;
   logic [1:0]    csr_index;
   logic [WB-1:0] csr_wdata;

   skp_req_if #(.WORD_BITS(WB)) req ();
   skp_rsp_if #(.WORD_BITS(WB)) rsp ();

   softened_kernel_potential #(.FRAC_BITS(FRAC), .WORD_BITS(WB)) dut (
      .clock(clock), .reset(reset), .req_ch(req.sink), .rsp_ch(rsp.source),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Copy of the register file as the block should see it.
   logic [WB-1:0] gm_reg;
   logic [WB-1:0] eps2_reg;
   kernel_type    kernel_reg;

   potential_beat_t expected_beats[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int burst_left = 0;
   int kernel_hits[4] = '{0, 0, 0, 0};

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? SAT64 : s[63:0];
   endfunction

   function automatic logic [63:0] sat_scale(logic [63:0] a, int k);
      logic [127:0] p;
      p = 128'(a) * 128'(k);
      return (p[127:64] != 0) ? SAT64 : p[63:0];
   endfunction

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p[127:64+FRAC] != 0) ? SAT64 : p[63+FRAC:FRAC];
   endfunction

   function automatic logic [63:0] fx_root(logic [63:0] x);
      logic [127:0] y;
      logic [63:0] q;
      logic [63:0] t;
      y = 128'(x) << FRAC;
      q = 0;
      for (int i = 63; i >= 0; i--) begin
         t = q | (64'd1 << i);
         if (128'(t) * 128'(t) <= y) q = t;
      end
      return q;
   endfunction

   // Applies the mass factor with the sign of -GM and saturates to the word.
   function automatic logic [WB-1:0] apply_mass(logic [63:0] mag);
      logic [63:0] gabs;
      logic [63:0] p;
      logic [63:0] top;
      top = 64'd1 << (WB - 1);
      gabs = gm_reg[WB-1] ? 64'((-gm_reg) & WMAX) : 64'(gm_reg);
      p = fx_mul(gabs, mag);
      if (gm_reg[WB-1]) begin
         if (p > top - 1) p = top - 1;
         return p[WB-1:0];
      end
      if (p > top) p = top;
      return WB'(-p);
   endfunction

   function automatic potential_beat_t plummer_terms(logic [WB-1:0] r2);
      logic [63:0] s, x, m0, m1, m2, m3, m4, h, q, pot, frc;
      potential_beat_t b;
      s = sat_add(64'(r2), 64'(eps2_reg));
      if (s == 0) s = 1;
      x = 64'((128'd1 << (2 * FRAC)) / 128'(s));
      m0 = fx_root(x);
      m1 = fx_mul(x, m0);
      m2 = sat_scale(fx_mul(x, m1), 3);
      m3 = sat_scale(fx_mul(x, m2), 5);
      m4 = sat_scale(fx_mul(x, m3), 7);
      h = 64'(eps2_reg) >> 1;
      q = 64'(eps2_reg) >> 2;
      case (kernel_reg)
         KERNEL_P1: begin
            pot = sat_add(m0, fx_mul(h, m1));
            frc = sat_add(m1, fx_mul(h, m2));
         end
         KERNEL_P2: begin
            pot = sat_add(m0, fx_mul(h, sat_add(m1, fx_mul(h, m2))));
            frc = sat_add(m1, fx_mul(h, sat_add(m2, fx_mul(h, m3))));
         end
         KERNEL_P3: begin
            pot = sat_add(m0, fx_mul(h, sat_add(m1, fx_mul(q, sat_add(m2, fx_mul(h, m3))))));
            frc = sat_add(m1, fx_mul(h, sat_add(m2, fx_mul(q, sat_add(m3, fx_mul(h, m4))))));
         end
         default: begin
            pot = m0;
            frc = m1;
         end
      endcase
      b.potential = apply_mass(pot);
      b.force_factor = apply_mass(frc);
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
      errors++;
      $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
   endtask

   // Result checker; the receiver periodically draws one of four stall modes at random.
   int stall_cycle = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      potential_beat_t want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_beats.size() == 0) begin
               errors++;
               $display("UNEXPECTED result beat: %h %h", rsp.potential, rsp.force_factor);
            end else begin
               want = expected_beats.pop_front();
               if (rsp.potential !== want.potential)
                  report_mismatch("potential", rsp.potential, want.potential);
               if (rsp.force_factor !== want.force_factor)
                  report_mismatch("force_factor", rsp.force_factor, want.force_factor);
               beats_checked++;
            end
         end
         stall_cycle++;
         if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 9) < 7);
            2: rsp.ready <= (stall_cycle % 5 != 0);
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_distance(logic [WB-1:0] r2);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req.valid <= 1'b1;
      req.radius_sq <= r2;
      do @(posedge clock); while (!(req.valid && req.ready));
      expected_beats.push_back(plummer_terms(r2));
      kernel_hits[kernel_reg]++;
      beats_sent++;
      burst_left--;
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [WB-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MASS_TERM:    gm_reg = value;
         CSR_SOFTENING_SQ: eps2_reg = value;
         default:          kernel_reg = kernel_type'(value[1:0]);
      endcase
   endtask

   task automatic configure(logic [WB-1:0] gm, logic [WB-1:0] eps2, kernel_type k);
      wait_idle();
      write_csr(CSR_MASS_TERM, gm);
      write_csr(CSR_SOFTENING_SQ, eps2);
      write_csr(CSR_KERNEL_SELECT, WB'(k));
      csr_wen <= 1'b0;
   endtask

   function automatic logic [WB-1:0] random_distance();
      logic [WB-1:0] v;
      v = WB'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, WB - 1);
      return v;
   endfunction

   task automatic test_reset_defaults();
      send_distance('0);
      send_distance(WB'(1));
      send_distance(WB'(1) << FRAC);
      send_distance(WMAX);
   endtask

   task automatic test_kernels();
      for (int k = 0; k < 4; k++) begin
         configure(WB'(1) << FRAC, WB'(1) << FRAC, kernel_type'(k));
         send_distance('0);
         send_distance(WB'(3) << (FRAC - 2));
         send_distance(WMAX);
      end
   endtask

   task automatic test_mass_extremes();
      logic [WB-1:0] masses[4];
      masses = '{{1'b0, {(WB-1){1'b1}}}, {1'b1, {(WB-1){1'b0}}}, '0, WMAX};
      foreach (masses[i]) begin
         configure(masses[i], WB'(1) << (FRAC - 4), KERNEL_P3);
         send_distance('0);
         send_distance(WB'(5) << FRAC);
      end
   endtask

   // Smallest, largest and zero softening; zero with zero distance saturates.
   task automatic test_softening();
      logic [WB-1:0] eps[3];
      eps = '{WB'(1), WMAX, '0};
      foreach (eps[i]) begin
         configure(WB'(1) << FRAC, eps[i], KERNEL_P2);
         send_distance('0);
         send_distance(WB'(1));
      end
   endtask

   task automatic test_random_streams();
      logic [WB-1:0] gm, eps2;
      for (int phase = 0; phase < 10; phase++) begin
         gm = WB'({$urandom, $urandom}) >> $urandom_range(0, WB - 1);
         if ($urandom_range(0, 1)) gm = -gm;
         eps2 = WB'({$urandom, $urandom}) >> $urandom_range(0, WB - 1);
         if (phase == 0) eps2 = WMAX;
         if (phase == 1) eps2 = WB'(1);
         if (eps2 == 0) eps2 = WB'(1);
         configure(gm, eps2, kernel_type'(phase % 4));
         repeat (110) send_distance(random_distance());
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.radius_sq = '0;
      gm_reg = WB'(1) << FRAC;
      eps2_reg = WB'(1) << FRAC;
      kernel_reg = KERNEL_PLUMMER;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_kernels();
      test_mass_extremes();
      test_softening();
      test_random_streams();

      wait_idle();
      repeat (140) @(posedge clock);
      $display("Sent %0d distance beats, checked %0d results.", beats_sent, beats_checked);
      $display("Beats per kernel: Plummer %0d, P1 %0d, P2 %0d, P3 %0d.",
               kernel_hits[0], kernel_hits[1], kernel_hits[2], kernel_hits[3]);
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench failed");
      $finish;
   end

endmodule
